[hdl/rhc_pkg.sv]
// Shared types and constants for the RGB to HSL conversion pipeline.
package rhc_pkg;

  localparam int DIV_STAGES_DEF = 4;

  localparam int CH_W     = 8;
  localparam int HUE_W    = 15;
  localparam int FRAC_W   = 16;
  localparam int DIV_DW   = 8;
  localparam int SAT_QW   = 16;
  localparam int HUE_QW   = 12;
  localparam int SAT_NW   = DIV_DW + SAT_QW;
  localparam int HUE_NW   = DIV_DW + HUE_QW;

  localparam logic [HUE_W-1:0] HUE_SECTOR = 15'd3840;
  localparam logic [HUE_W-1:0] HUE_FULL   = 15'd23040;

  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } rhc_sector_t;

  // Per-item flags and lightness that ride alongside the dividers
  typedef struct packed {
    logic              grey;
    logic              neg;
    rhc_sector_t       sector;
    logic [FRAC_W-1:0] light;
  } rhc_side_t;

endpackage

[hdl/rgb_to_hsl_convert_unit.sv]
// RGB to HSL conversion pipeline, top level.
// Throughput: one pixel per clock unless hsl_stall is high; every stage advances when
// its successor has room, so bubbles fill up behind a stalled result and nothing is
// dropped or repeated. Depth is set by the two restoring dividers, with QW / DIV_STAGES
// quotient bits per stage, rounded up.
// Reset (rst, synchronous) clears all valid bits; data registers are not reset.
module rgb_to_hsl_convert_unit import rhc_pkg::*; #(
  parameter int DIV_STAGES = DIV_STAGES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              pix_valid,
  output logic              pix_stall,
  input  logic [CH_W-1:0]   red,
  input  logic [CH_W-1:0]   green,
  input  logic [CH_W-1:0]   blue,
  output logic              hsl_valid,
  input  logic              hsl_stall,
  output logic [HUE_W-1:0]  hue,
  output logic [FRAC_W-1:0] saturation,
  output logic [FRAC_W-1:0] lightness
);

  // stage map: 0 decode, 1 products, 2..DIV_STAGES+1 dividers, last output
  localparam int NSTG  = DIV_STAGES + 3;
  localparam int OSTG  = NSTG - 1;

  logic [NSTG-1:0] en;

  logic [SAT_NW-1:0] sat_num;
  logic [DIV_DW-1:0] sat_den;
  logic [HUE_NW-1:0] hue_num;
  logic [DIV_DW-1:0] hue_den;
  rhc_side_t         side1;
  rhc_side_t         side_q [DIV_STAGES];

  logic [SAT_QW-1:0] sat_q;
  logic [HUE_QW-1:0] hq;
  logic              hue_rnz;

  logic [HUE_W-1:0]  base;
  logic [HUE_W-1:0]  hceil;
  logic [HUE_W-1:0]  hue_next;

  rhc_pipe_ctrl #(
    .NSTG (NSTG)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (pix_valid),
    .out_stall (hsl_stall),
    .in_stall  (pix_stall),
    .out_valid (hsl_valid),
    .en        (en)
  );

  rhc_front u_front (
    .clk     (clk),
    .en      (en[1:0]),
    .red     (red),
    .green   (green),
    .blue    (blue),
    .sat_num (sat_num),
    .sat_den (sat_den),
    .hue_num (hue_num),
    .hue_den (hue_den),
    .side    (side1)
  );

  // saturation: d * 65535 / den, quotient fits 16 bits since d <= den
  // the remainder of the saturation divide is not needed
  rhc_div_pipe #(
    .STAGES (DIV_STAGES),
    .DW     (DIV_DW),
    .QW     (SAT_QW)
  ) u_sat_div (
    .clk    (clk),
    .en     (en[DIV_STAGES+1:2]),
    .num    (sat_num),
    .den    (sat_den),
    .quo    (sat_q),
    .rem_nz ()
  );

  // hue offset: |x| * 3840 / d, at most 3840 since |x| <= d
  rhc_div_pipe #(
    .STAGES (DIV_STAGES),
    .DW     (DIV_DW),
    .QW     (HUE_QW)
  ) u_hue_div (
    .clk    (clk),
    .en     (en[DIV_STAGES+1:2]),
    .num    (hue_num),
    .den    (hue_den),
    .quo    (hq),
    .rem_nz (hue_rnz)
  );

  // flags and lightness travel beside the dividers
  always_ff @(posedge clk) begin
    if (en[2]) begin
      side_q[0] <= side1;
    end
    for (int s = 1; s < DIV_STAGES; s++) begin
      if (en[s+2]) begin
        side_q[s] <= side_q[s-1];
      end
    end
  end

  // negative ratio floors away from zero: subtract the ceiling
  always_comb begin
    hceil = HUE_W'(hq) + HUE_W'(hue_rnz);
    case (side_q[DIV_STAGES-1].sector)
      SEC_RED:   base = side_q[DIV_STAGES-1].neg ? HUE_FULL : '0;
      SEC_GREEN: base = HUE_SECTOR << 1;
      SEC_BLUE:  base = HUE_SECTOR << 2;
      default:   base = '0;
    endcase
    if (side_q[DIV_STAGES-1].grey) begin
      hue_next = '0;
    end else if (side_q[DIV_STAGES-1].neg) begin
      hue_next = base - hceil;
    end else begin
      hue_next = base + HUE_W'(hq);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (en[OSTG]) begin
      hue        <= hue_next;
      saturation <= side_q[DIV_STAGES-1].grey ? '0 : sat_q;
      lightness  <= side_q[DIV_STAGES-1].light;
    end
  end

endmodule

[hdl/rhc_pipe_ctrl.sv]
// Valid bits and per-stage enables of the conversion pipeline.
module rhc_pipe_ctrl #(
  parameter int NSTG = 7
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic            out_stall,
  output logic            in_stall,
  output logic            out_valid,
  output logic [NSTG-1:0] en
);

  logic [NSTG-1:0] valid;
  logic [NSTG-1:0] valid_in;
  logic [NSTG:0]   ready;

  // a stage may load when it is empty or its successor loads too
  always_comb begin
    ready[NSTG] = !out_stall;
    for (int k = NSTG - 1; k >= 0; k--) begin
      ready[k] = !valid[k] || ready[k+1];
    end
  end

  // valid bit each stage takes when it loads
  assign valid_in  = {valid[NSTG-2:0], in_valid};

  assign en        = ready[NSTG-1:0];
  assign in_stall  = !ready[0];
  assign out_valid = valid[NSTG-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      for (int k = 0; k < NSTG; k++) begin
        if (en[k]) begin
          valid[k] <= valid_in[k];
        end
      end
    end
  end

endmodule

[hdl/rhc_front.sv]
// Front stages: channel max/min decode, then the constant products.
module rhc_front import rhc_pkg::*; (
  input  logic              clk,
  input  logic [1:0]        en,
  input  logic [CH_W-1:0]   red,
  input  logic [CH_W-1:0]   green,
  input  logic [CH_W-1:0]   blue,
  output logic [SAT_NW-1:0] sat_num,
  output logic [DIV_DW-1:0] sat_den,
  output logic [HUE_NW-1:0] hue_num,
  output logic [DIV_DW-1:0] hue_den,
  output rhc_side_t         side
);

  logic [CH_W-1:0] mx, mn, lo_ch;
  rhc_sector_t     sec;
  logic [CH_W:0]   sum;
  logic signed [CH_W:0] x;

  logic [CH_W-1:0] d0, den0, ax0;
  logic [CH_W:0]   sum0;
  logic            neg0, grey0;
  rhc_sector_t     sec0;

  logic [CH_W+8:0] lprod;

  always_comb begin
    if (red >= green && red >= blue) begin
      sec = SEC_RED;
      mx  = red;
    end else if (green >= blue) begin
      sec = SEC_GREEN;
      mx  = green;
    end else begin
      sec = SEC_BLUE;
      mx  = blue;
    end
    lo_ch = (green < blue) ? green : blue;
    mn    = (red < lo_ch) ? red : lo_ch;
    sum   = {1'b0, mx} + {1'b0, mn};
    case (sec)
      SEC_RED:   x = $signed({1'b0, green}) - $signed({1'b0, blue});
      SEC_GREEN: x = $signed({1'b0, blue}) - $signed({1'b0, red});
      SEC_BLUE:  x = $signed({1'b0, red}) - $signed({1'b0, green});
      default:   x = '0;
    endcase
  end

  // stage 0
  always_ff @(posedge clk) begin
    if (en[0]) begin
      d0    <= mx - mn;
      grey0 <= (mx == mn);
      sum0  <= sum;
      den0  <= (sum <= 9'd255) ? sum[CH_W-1:0] : CH_W'(9'd510 - sum);
      neg0  <= x[CH_W];
      ax0   <= x[CH_W] ? CH_W'(-x) : x[CH_W-1:0];
      sec0  <= sec;
    end
  end

  // lightness = sum * 65535 / 510 = sum * 257 / 2
  assign lprod = {sum0, 8'h00} + {8'h00, sum0};

  // stage 1: d * 65535 and |x| * 3840 by shift and subtract
  always_ff @(posedge clk) begin
    if (en[1]) begin
      sat_num     <= {d0, 16'h0000} - {16'h0000, d0};
      hue_num     <= {ax0, 12'h000} - {4'h0, ax0, 8'h00};
      sat_den     <= den0;
      hue_den     <= d0;
      side.grey   <= grey0;
      side.neg    <= neg0;
      side.sector <= sec0;
      side.light  <= lprod[CH_W+8:1];
    end
  end

endmodule

[hdl/rhc_div_pipe.sv]
// Pipelined restoring divider, QW / STAGES quotient bits per stage, rounded up.
module rhc_div_pipe #(
  parameter int STAGES = 4,
  parameter int DW     = 8,
  parameter int QW     = 16
) (
  input  logic             clk,
  input  logic [STAGES-1:0] en,
  input  logic [DW+QW-1:0] num,  // caller guarantees num < den * 2**QW
  input  logic [DW-1:0]    den,
  output logic [QW-1:0]    quo,
  output logic             rem_nz
);

  localparam int BPS = (QW + STAGES - 1) / STAGES;

  logic [DW-1:0] rem_q [STAGES];
  logic [QW-1:0] wk_q  [STAGES];
  logic [DW-1:0] den_q [STAGES];

  for (genvar s = 0; s < STAGES; s++) begin : g_stg
    logic [DW-1:0] rem_in, rem_nx, den_in;
    logic [QW-1:0] wk_in, wk_nx;

    if (s == 0) begin : g_first
      assign rem_in = num[DW+QW-1:QW];
      assign wk_in  = num[QW-1:0];
      assign den_in = den;
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign wk_in  = wk_q[s-1];
      assign den_in = den_q[s-1];
    end

    // work word: remaining dividend bits shift out, quotient bits shift in
    always_comb begin
      logic [DW:0] t;
      rem_nx = rem_in;
      wk_nx  = wk_in;
      for (int j = 0; j < BPS; j++) begin
        if (s * BPS + j < QW) begin
          t = {rem_nx, wk_nx[QW-1]};
          if (t >= {1'b0, den_in}) begin
            t     = t - {1'b0, den_in};
            wk_nx = {wk_nx[QW-2:0], 1'b1};
          end else begin
            wk_nx = {wk_nx[QW-2:0], 1'b0};
          end
          rem_nx = t[DW-1:0];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en[s]) begin
        rem_q[s] <= rem_nx;
        wk_q[s]  <= wk_nx;
        den_q[s] <= den_in;
      end
    end
  end

  assign quo    = wk_q[STAGES-1];
  assign rem_nz = |rem_q[STAGES-1];

endmodule

[hdl/rhc_checker.sv]
// Port-level checks of the conversion unit, bound to the top level.
module rhc_checker import rhc_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              hsl_valid,
  input logic              hsl_stall,
  input logic [HUE_W-1:0]  hue,
  input logic [FRAC_W-1:0] saturation,
  input logic [FRAC_W-1:0] lightness
);

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    hsl_valid && hsl_stall |=> hsl_valid && $stable(hue) && $stable(saturation)
      && $stable(lightness))
    else $error("stalled result changed");

  a_hue_range: assert property (@(posedge clk) disable iff (rst)
    hsl_valid |-> hue < HUE_FULL)
    else $error("hue out of range");

  // zero saturation only for grey pixels, and those have zero hue
  a_grey: assert property (@(posedge clk) disable iff (rst)
    hsl_valid && saturation == '0 |-> hue == '0)
    else $error("grey pixel with nonzero hue");

  a_black: assert property (@(posedge clk) disable iff (rst)
    hsl_valid && lightness == '0 |-> saturation == '0 && hue == '0)
    else $error("black pixel with color");

  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !hsl_valid)
    else $error("result valid right after reset");

endmodule

bind rgb_to_hsl_convert_unit rhc_checker u_rhc_checker (
  .clk        (clk),
  .rst        (rst),
  .hsl_valid  (hsl_valid),
  .hsl_stall  (hsl_stall),
  .hue        (hue),
  .saturation (saturation),
  .lightness  (lightness)
);

[sim/tb_rgb_to_hsl_convert_unit.sv]
// Self-checking testbench for the RGB to HSL conversion pipeline.
`timescale 1ns / 100ps

module tb_rgb_to_hsl_convert_unit;
  import rhc_pkg::*;

  localparam int FRAC_ONE   = (1 << FRAC_W) - 1;
  localparam int RAND_ITEMS = 450;
  localparam int TAIL_CYC   = 20;    // idle wait after the last result is out
  localparam int WDOG_LIMIT = 2000;  // cycles with no item moving on either side

  // One result item: hue in 1/64 degree, two unsigned fractions.
  typedef struct packed {
    logic [HUE_W-1:0]  hue;
    logic [FRAC_W-1:0] saturation;
    logic [FRAC_W-1:0] lightness;
  } hsl_t;

  // Directed row: a pixel and, where known by inspection, its result.
  typedef struct {
    logic [CH_W-1:0] r;
    logic [CH_W-1:0] g;
    logic [CH_W-1:0] b;
    bit              fixed;
    hsl_t            val;
  } pix_row_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              pix_valid = 1'b0;
  logic              pix_stall;
  logic [CH_W-1:0]   red = '0;
  logic [CH_W-1:0]   green = '0;
  logic [CH_W-1:0]   blue = '0;
  logic              hsl_valid;
  logic              hsl_stall = 1'b0;
  logic [HUE_W-1:0]  hue;
  logic [FRAC_W-1:0] saturation;
  logic [FRAC_W-1:0] lightness;

  hsl_t     pend_hsl = '0;   // result owed by the pixel now on the input
  hsl_t     hsl_q[$];        // results owed by accepted pixels, oldest first
  pix_row_t dir_rows[$];
  int       err_cnt = 0;
  int       quiet_cyc = 0;
  bit       idle_on = 1'b1;  // sender gaps enabled
  bit       stall_on = 1'b1; // receiver stalls enabled

  rgb_to_hsl_convert_unit u_dut (
    .clk        (clk),
    .rst        (rst),
    .pix_valid  (pix_valid),
    .pix_stall  (pix_stall),
    .red        (red),
    .green      (green),
    .blue       (blue),
    .hsl_valid  (hsl_valid),
    .hsl_stall  (hsl_stall),
    .hue        (hue),
    .saturation (saturation),
    .lightness  (lightness)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------

  // Division rounding toward minus infinity, den > 0.
  function automatic int floor_ratio(input int num, input int den);
    int q;
    q = num / den;
    if ((num % den != 0) && (num < 0)) q = q - 1;
    return q;
  endfunction

  function automatic hsl_t predict_hsl(input logic [CH_W-1:0] r, g, b);
    int   ri, gi, bi, hi, lo, span, total, h, sector;
    hsl_t res;
    ri = r;
    gi = g;
    bi = b;
    hi = ri;
    lo = ri;
    if (gi > hi) hi = gi;
    if (bi > hi) hi = bi;
    if (gi < lo) lo = gi;
    if (bi < lo) lo = bi;
    span   = hi - lo;
    total  = hi + lo;
    sector = int'(HUE_SECTOR);
    h      = 0;
    res.saturation = '0;
    res.lightness  = FRAC_W'((total * FRAC_ONE) / 510);
    if (span != 0) begin
      // below mid grey the ratio is over the sum, above it over the headroom
      if (total <= 255) res.saturation = FRAC_W'((span * FRAC_ONE) / total);
      else              res.saturation = FRAC_W'((span * FRAC_ONE) / (510 - total));
      // red wins ties for the largest channel, then green
      if (ri == hi) begin
        h = floor_ratio(sector * (gi - bi), span);
        if (h < 0) h = h + int'(HUE_FULL);
      end else if (gi == hi) begin
        h = 2 * sector + floor_ratio(sector * (bi - ri), span);
      end else begin
        h = 4 * sector + floor_ratio(sector * (ri - gi), span);
      end
    end
    res.hue = HUE_W'(h);
    return res;
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------

  task automatic add_row(input logic [CH_W-1:0] r, g, b, input bit fixed,
                         input int h, input int s, input int l);
    pix_row_t row;
    row.r     = r;
    row.g     = g;
    row.b     = b;
    row.fixed = fixed;
    row.val   = '{hue: HUE_W'(h), saturation: FRAC_W'(s), lightness: FRAC_W'(l)};
    dir_rows.push_back(row);
  endtask

  // Channel value biased toward the ends of the range.
  function automatic logic [CH_W-1:0] rand_chan();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return CH_W'($urandom_range(0, 3));
      3:       return CH_W'($urandom_range(252, 255));
      default: return CH_W'($urandom);
    endcase
  endfunction

  // Entered at a falling edge; returns at the falling edge after acceptance.
  // A zero gap keeps pix_valid high straight into the next item.
  task automatic send_pixel(input logic [CH_W-1:0] r, g, b, input hsl_t want);
    int gap;
    gap = idle_on ? $urandom_range(0, 13) : 0;
    if (gap > 0) begin
      pix_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    red       <= r;
    green     <= g;
    blue      <= b;
    pend_hsl  <= want;
    pix_valid <= 1'b1;
    do @(posedge clk); while (!(pix_valid && !pix_stall));
    @(negedge clk);
  endtask

  // Called at a falling edge; holds the input idle until every owed result is out.
  task automatic drain_results();
    pix_valid <= 1'b0;
    while (hsl_q.size() != 0) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------
  // Sender: directed table, then random pixels
  // ---------------------------------------------------------------------
  initial begin
    logic [CH_W-1:0] px[3];
    logic [CH_W-1:0] tmp;
    int              shape, j, top, bot;

    // extremes and primaries, readable by hand
    add_row(8'd0,   8'd0,   8'd0,   1, 0,     0,     0);
    add_row(8'd255, 8'd255, 8'd255, 1, 0,     0,     65535);
    add_row(8'd128, 8'd128, 8'd128, 1, 0,     0,     32896);
    add_row(8'd255, 8'd0,   8'd0,   1, 0,     65535, 32767);
    add_row(8'd0,   8'd255, 8'd0,   1, 7680,  65535, 32767);
    add_row(8'd0,   8'd0,   8'd255, 1, 15360, 65535, 32767);
    // ties for the max: red over green, red over blue, green over blue
    add_row(8'd255, 8'd255, 8'd0,   1, 3840,  65535, 32767);
    add_row(8'd255, 8'd0,   8'd255, 1, 19200, 65535, 32767);
    add_row(8'd0,   8'd255, 8'd255, 1, 11520, 65535, 32767);
    // the rest go through the predictor
    add_row(8'd255, 8'd0,   8'd1,   0, 0, 0, 0);  // red max, hue wraps below zero
    add_row(8'd1,   8'd0,   8'd0,   0, 0, 0, 0);
    add_row(8'd0,   8'd1,   8'd0,   0, 0, 0, 0);
    add_row(8'd0,   8'd0,   8'd1,   0, 0, 0, 0);
    add_row(8'd255, 8'd254, 8'd254, 0, 0, 0, 0);
    add_row(8'd254, 8'd255, 8'd255, 0, 0, 0, 0);
    add_row(8'd128, 8'd127, 8'd127, 0, 0, 0, 0);  // sum right at 255
    add_row(8'd128, 8'd128, 8'd127, 0, 0, 0, 0);
    add_row(8'd129, 8'd128, 8'd128, 0, 0, 0, 0);  // sum just past 255
    add_row(8'd200, 8'd100, 8'd50,  0, 0, 0, 0);
    add_row(8'd50,  8'd200, 8'd100, 0, 0, 0, 0);
    add_row(8'd100, 8'd50,  8'd200, 0, 0, 0, 0);
    add_row(8'd170, 8'd85,  8'd85,  0, 0, 0, 0);
    add_row(8'd85,  8'd170, 8'd255, 0, 0, 0, 0);
    add_row(8'd1,   8'd2,   8'd3,   0, 0, 0, 0);
    add_row(8'd254, 8'd1,   8'd128, 0, 0, 0, 0);

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      send_pixel(dir_rows[i].r, dir_rows[i].g, dir_rows[i].b,
                 dir_rows[i].fixed ? dir_rows[i].val
                                   : predict_hsl(dir_rows[i].r, dir_rows[i].g, dir_rows[i].b));
    end

    // let the pipe empty out completely once before the random part
    drain_results();

    for (int n = 0; n < RAND_ITEMS; n++) begin
      // new pacing phase every 50 items; some phases run back to back
      if (n % 50 == 0) idle_on = ($urandom_range(0, 3) != 0);
      if (n == RAND_ITEMS / 2) drain_results();
      shape = $urandom_range(0, 7);
      case (shape)
        0: begin  // grey
          px[0] = rand_chan();
          px[1] = px[0];
          px[2] = px[0];
        end
        1: begin  // two channels equal, tie for max or min
          px[0] = rand_chan();
          px[1] = px[0];
          px[2] = rand_chan();
        end
        2: begin  // max + min close to 255, where saturation switches formula
          top = $urandom_range(128, 255);
          bot = 255 - top + $urandom_range(0, 2) - 1;
          if (bot < 0) bot = 0;
          if (bot > top) bot = top;
          px[0] = CH_W'(top);
          px[1] = CH_W'(bot);
          px[2] = CH_W'($urandom_range(bot, top));
        end
        default: begin
          px[0] = rand_chan();
          px[1] = rand_chan();
          px[2] = rand_chan();
        end
      endcase
      // spread the roles over red, green and blue
      for (int k = 2; k > 0; k--) begin
        j     = $urandom_range(0, k);
        tmp   = px[k];
        px[k] = px[j];
        px[j] = tmp;
      end
      send_pixel(px[0], px[1], px[2], predict_hsl(px[0], px[1], px[2]));
    end

    pix_valid <= 1'b0;
    while (hsl_q.size() != 0) @(negedge clk);
    repeat (TAIL_CYC) @(negedge clk);
    if (err_cnt == 0) begin
      $display("tb_rgb_to_hsl_convert_unit: PASS");
    end else begin
      $display("tb_rgb_to_hsl_convert_unit: FAIL");
    end
    $finish;
  end

  // ---------------------------------------------------------------------
  // Receiver: random stall before each result item, quiet phases too
  // ---------------------------------------------------------------------
  initial begin
    int stall_left, res_cnt;
    stall_left = 0;
    res_cnt    = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        hsl_stall <= 1'b1;
        stall_left--;
      end else begin
        hsl_stall <= 1'b0;
      end
      @(posedge clk);
      if (!rst && hsl_valid && !hsl_stall) begin
        res_cnt++;
        if (res_cnt % 50 == 0) stall_on = ($urandom_range(0, 3) != 0);
        stall_left = stall_on ? $urandom_range(0, 13) : 0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Scoreboard and watchdog. Output is checked before the input push, so
  // a result can never be matched against the pixel taken on the same edge.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    hsl_t want;
    bit   moved;
    moved = 1'b0;
    if (!rst) begin
      if (hsl_valid && !hsl_stall) begin
        moved = 1'b1;
        if (hsl_q.size() == 0) begin
          $display("%0t: result with none owed: hue %0d sat %0d light %0d",
                   $time, hue, saturation, lightness);
          err_cnt++;
        end else begin
          want = hsl_q.pop_front();
          if (hue !== want.hue) begin
            $display("%0t: hue expected %0d actual %0d", $time, want.hue, hue);
            err_cnt++;
          end
          if (saturation !== want.saturation) begin
            $display("%0t: saturation expected %0d actual %0d",
                     $time, want.saturation, saturation);
            err_cnt++;
          end
          if (lightness !== want.lightness) begin
            $display("%0t: lightness expected %0d actual %0d",
                     $time, want.lightness, lightness);
            err_cnt++;
          end
        end
      end
      if (pix_valid && !pix_stall) begin
        moved = 1'b1;
        hsl_q.push_back(pend_hsl);
      end
    end
    if (moved) begin
      quiet_cyc <= 0;
    end else if (quiet_cyc >= WDOG_LIMIT) begin
      $display("%0t: no item moved for %0d cycles, %0d results owed",
               $time, quiet_cyc, hsl_q.size());
      $display("tb_rgb_to_hsl_convert_unit: FAIL");
      $finish;
    end else begin
      quiet_cyc <= quiet_cyc + 1;
    end
  end

endmodule

[sim.f]
hdl/rhc_pkg.sv
hdl/rhc_pipe_ctrl.sv
hdl/rhc_front.sv
hdl/rhc_div_pipe.sv
hdl/rgb_to_hsl_convert_unit.sv
hdl/rhc_checker.sv
sim/tb_rgb_to_hsl_convert_unit.sv
